[hdl/multichannel_decimating_averager_defines.svh]
// assertion macros for the decimating averager checker
// no dependencies; included by the checker file only
`ifndef MULTICHANNEL_DECIMATING_AVERAGER_DEFINES_SVH
`define MULTICHANNEL_DECIMATING_AVERAGER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define MCDA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mcda_pkg.sv]
// shared types and constants for the decimating averager
// no dependencies; used by every other file of the block but the macro header
package mcda_pkg;

  localparam int AVG_SHIFT    = 22;
  localparam int CMD_W        = 2;
  localparam int CH_W         = 2;
  localparam int AVG_W        = 32;
  localparam int EN_W         = 4;
  localparam int MIN_W        = 16;
  localparam int CFG_CHANNELS = 4;
  localparam int REG_IDX_W    = 3;
  localparam int ADDR_W       = REG_IDX_W + 2;
  localparam int DATA_W       = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE  = 3'd0,
    REG_MIN_CH0 = 3'd1,
    REG_MIN_CH1 = 3'd2,
    REG_MIN_CH2 = 3'd3,
    REG_MIN_CH3 = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic [EN_W-1:0]                    enable;
    logic [CFG_CHANNELS-1:0][MIN_W-1:0] min_count;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/mcda_if.sv]
// valid/ready channel interfaces for input items and results
// depends on mcda_pkg
interface mcda_item_if import mcda_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [CH_W-1:0]        channel;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, command, channel, sample, input ready);
  modport sink (input valid, command, channel, sample, output ready);
endinterface

interface mcda_result_if import mcda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  out_channel;
  logic [AVG_W-1:0] average;

  modport source (output valid, out_channel, average, input ready);
  modport sink (input valid, out_channel, average, output ready);
endinterface

[hdl/mcda_cfg.sv]
// apb register file: channel enables and per-channel minimum counts
// depends on mcda_pkg
module mcda_cfg import mcda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  logic [EN_W-1:0]                    enable;
  logic [CFG_CHANNELS-1:0][MIN_W-1:0] min_count;
  logic                               wr;
  logic [REG_IDX_W-1:0]               idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= '0;
      min_count <= {CFG_CHANNELS{MIN_W'(1)}};
    end else if (wr) begin
      case (idx)
        REG_ENABLE:  enable       <= pwdata[EN_W-1:0];
        REG_MIN_CH0: min_count[0] <= pwdata[MIN_W-1:0];
        REG_MIN_CH1: min_count[1] <= pwdata[MIN_W-1:0];
        REG_MIN_CH2: min_count[2] <= pwdata[MIN_W-1:0];
        REG_MIN_CH3: min_count[3] <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:  prdata = {{(DATA_W-EN_W){1'b0}}, enable};
      REG_MIN_CH0: prdata = {{(DATA_W-MIN_W){1'b0}}, min_count[0]};
      REG_MIN_CH1: prdata = {{(DATA_W-MIN_W){1'b0}}, min_count[1]};
      REG_MIN_CH2: prdata = {{(DATA_W-MIN_W){1'b0}}, min_count[2]};
      REG_MIN_CH3: prdata = {{(DATA_W-MIN_W){1'b0}}, min_count[3]};
      default:     prdata = '0;
    endcase
  end

  assign cfg.enable    = enable;
  assign cfg.min_count = min_count;

endmodule

[hdl/mcda_bank.sv]
// per-channel running sums and sample counts, with tick eligibility
// depends on mcda_pkg
module mcda_bank import mcda_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 10,
  parameter int COUNT_BITS   = 16,
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_regs_t              cfg,
  input  logic                   item_fire,
  input  logic [CMD_W-1:0]       command,
  input  logic [CH_W-1:0]        channel,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   emit,
  output logic [SUM_BITS-1:0]    sel_sum,
  output logic [COUNT_BITS-1:0]  sel_count
);

  localparam int CMP_W = (COUNT_BITS > MIN_W) ? COUNT_BITS : MIN_W;

  logic [SUM_BITS-1:0]   sums   [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] counts [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] enabled, hit, eligible;
  logic do_add, do_tick, do_flush;

  assign do_add   = item_fire && (command == CMD_ADD);
  assign do_tick  = item_fire && (command == CMD_TICK);
  assign do_flush = item_fire && (command == CMD_FLUSH);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    if (c < CFG_CHANNELS) begin : g_cfg
      assign enabled[c]  = cfg.enable[c];
      assign eligible[c] = (counts[c] != '0) &&
                           (CMP_W'(counts[c]) >= CMP_W'(cfg.min_count[c]));
    end else begin : g_nocfg
      assign enabled[c]  = 1'b0;
      assign eligible[c] = 1'b0;
    end
    assign hit[c] = ({{(32-CH_W){1'b0}}, channel} == 32'(c)) && enabled[c];
  end

  // a closed channel is held at zero, so it always reopens from empty
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (rst || !enabled[ch] || do_flush || (do_tick && hit[ch] && eligible[ch])) begin
        sums[ch]   <= '0;
        counts[ch] <= '0;
      end else if (do_add && hit[ch] && (counts[ch] != '1)) begin
        sums[ch]   <= sums[ch] + SUM_BITS'(sample);
        counts[ch] <= counts[ch] + 1'b1;
      end
    end
  end

  always_comb begin
    sel_sum   = '0;
    sel_count = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (hit[ch]) begin
        sel_sum   = sums[ch];
        sel_count = counts[ch];
      end
    end
  end

  assign emit = do_tick && |(hit & eligible);

endmodule

[hdl/mcda_div.sv]
// bit-serial restoring divider: (sum << 22) / count, one quotient bit per cycle
// depends on mcda_pkg
module mcda_div import mcda_pkg::*; #(
  parameter int SUM_BITS   = 26,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend_sum,
  input  logic [COUNT_BITS-1:0] divisor,
  input  logic                  take,
  output div_stat_t             stat,
  output logic [AVG_W-1:0]      quotient
);

  localparam int DIVIDEND_W = SUM_BITS + AVG_SHIFT;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  div_state_t              state, state_next;
  logic [DIVIDEND_W-1:0]   dividend;
  logic [COUNT_BITS-1:0]   divisor_q;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   rem_next;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;
  logic                    fits;
  logic [STEP_W-1:0]       steps;
  logic                    last_step;

  // remainder stays below the divisor, so the difference fits its width
  assign trial     = {rem, dividend[DIVIDEND_W-1]};
  assign fits      = trial >= {1'b0, divisor_q};
  assign diff      = trial - {1'b0, divisor_q};
  assign rem_next  = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign last_step = steps == STEP_W'(DIVIDEND_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.busy  = 1'b0;
    stat.done  = 1'b0;
    case (state)
      DIV_IDLE: begin
        if (start) state_next = DIV_RUN;
      end
      DIV_RUN: begin
        stat.busy = 1'b1;
        if (last_step) state_next = DIV_DONE;
      end
      DIV_DONE: begin
        stat.busy = 1'b1;
        stat.done = 1'b1;
        if (take) state_next = DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  // only the low quotient bits are kept, higher ones shift out
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      dividend  <= {dividend_sum, {AVG_SHIFT{1'b0}}};
      divisor_q <= divisor;
      rem       <= '0;
      quotient  <= '0;
      steps     <= '0;
    end else if (state == DIV_RUN) begin
      dividend  <= {dividend[DIVIDEND_W-2:0], 1'b0};
      rem       <= rem_next;
      quotient  <= {quotient[AVG_W-2:0], fits};
      steps     <= steps + 1'b1;
    end
  end

endmodule

[hdl/multichannel_decimating_averager.sv]
// Multichannel decimating averager: per-channel accumulate and dump.
// Input channel (items): command, channel, sample. Add sample and flush
// never give a result. A tick on an open channel whose count is nonzero
// and has reached its minimum starts a bit-serial division of
// (sum << 22) by the count and clears that channel.
// Result channel (results): out_channel and average, from an output
// register, so a finished result may wait while the next item is taken.
// A tick that emits passes through the restoring divider's run and done
// states into the output register; items stall during the division.
// If the receiver stalls, the divider holds its quotient until the output
// register frees, and only then takes the next item.
// Registers over APB: enable at 0x0, minimum counts at 0x4 to 0x10.
// Reset (synchronous, active high) clears all sums and counts, closes all
// channels, sets every minimum count to one and drops any result.
// Depends on mcda_pkg, mcda_if, mcda_cfg, mcda_bank and mcda_div.
module multichannel_decimating_averager import mcda_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 10,
  parameter int COUNT_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  mcda_item_if.sink         items,
  mcda_result_if.source     results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

  cfg_regs_t             cfg;
  div_stat_t             stat;
  logic                  item_fire;
  logic                  emit;
  logic                  take;
  logic [SUM_BITS-1:0]   sel_sum;
  logic [COUNT_BITS-1:0] sel_count;
  logic [AVG_W-1:0]      quotient;
  logic [CH_W-1:0]       div_channel;
  logic                  out_valid;
  logic [CH_W-1:0]       out_channel;
  logic [AVG_W-1:0]      average;

  assign items.ready = !stat.busy;
  assign item_fire   = items.valid && items.ready;
  assign take        = stat.done && (!out_valid || results.ready);

  mcda_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcda_bank #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_fire (item_fire),
    .command   (items.command),
    .channel   (items.channel),
    .sample    (items.sample),
    .emit      (emit),
    .sel_sum   (sel_sum),
    .sel_count (sel_count)
  );

  mcda_div #(
    .SUM_BITS   (SUM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (emit),
    .dividend_sum (sel_sum),
    .divisor      (sel_count),
    .take         (take),
    .stat         (stat),
    .quotient     (quotient)
  );

  always_ff @(posedge clk) begin
    if (emit) div_channel <= items.channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_channel <= div_channel;
      average     <= quotient;
    end
  end

  assign results.valid       = out_valid;
  assign results.out_channel = out_channel;
  assign results.average     = average;

endmodule

[hdl/mcda_checker.sv]
// port-level checks for the decimating averager, bound to the top level
// depends on mcda_pkg and the assertion macro header
`include "multichannel_decimating_averager_defines.svh"

module mcda_checker import mcda_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [CMD_W-1:0] in_command,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CH_W-1:0]  out_channel,
  input logic [AVG_W-1:0] average
);

  `MCDA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(average) && $stable(out_channel), "result changed while stalled")

  // input only stalls after a tick transaction starts a division
  `MCDA_ASSERT_SAME(a_stall_from_tick, clk, rst, $fell(in_ready),
    $past(in_valid && (in_command == CMD_TICK)), "input stalled without a tick")

  // a new result comes from the divider handing over, which frees the input
  `MCDA_ASSERT_SAME(a_result_frees_input, clk, rst, $rose(out_valid),
    $rose(in_ready), "result appeared without divider hand-over")

endmodule

bind multichannel_decimating_averager mcda_checker u_mcda_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .in_command  (items.command),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_channel (results.out_channel),
  .average     (results.average)
);
